// ===== hdl/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// No dependencies; every other file of the block but lrupr_ram imports this package.
package lrupr_pkg;

  // Fixed widths of the channel fields and the configuration register.
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 3;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_FRAMES    = 8;
  localparam int DEF_PAGE_BITS = 16;

  // Reset value of frames_in_use, the configured frame count.
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TOUCH,
    S_FINISH
  } state_t;

  // Commands from the sequencer to the frame unit.
  typedef struct packed {
    logic clear;  // start of a new reference
    logic scan;   // read data valid during the lookup pass
    logic touch;  // read data valid during the rank update pass
  } unit_op_t;

  // Outcome of the lookup pass.
  typedef struct packed {
    logic hit;
    logic evict;
  } unit_stat_t;

endpackage

// ===== hdl/lrupr_ifs.sv =====
// Valid/ready channel interfaces for page references and results.
// Depends on lrupr_pkg for the field widths.
interface lrupr_in_if;
  import lrupr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink (input valid, input page, output ready);
endinterface

interface lrupr_out_if;
  import lrupr_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [FRAME_W-1:0] frame;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [CNT_W-1:0]   hits_so_far;
  logic [CNT_W-1:0]   faults_so_far;

  modport source (output valid, output hit, output frame, output evicted_valid,
                  output evicted_page, output hits_so_far, output faults_so_far,
                  input ready);
  modport sink (input valid, input hit, input frame, input evicted_valid,
                input evicted_page, input hits_so_far, input faults_so_far,
                output ready);
endinterface

// ===== hdl/lrupr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lrupr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lrupr_unit.sv =====
// Shared per-frame compare unit: lookup, empty search and oldest search
// during the scan pass, and the rank update during the touch pass.
// Depends on lrupr_pkg.
module lrupr_unit #(
  parameter int FRAMES    = lrupr_pkg::DEF_FRAMES,
  parameter int PAGE_BITS = lrupr_pkg::DEF_PAGE_BITS,
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int CW = $clog2(FRAMES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lrupr_pkg::unit_op_t    op,
  input  logic [IW-1:0]          idx,
  input  logic                   frame_valid,
  input  logic [PAGE_BITS-1:0]   rd_page,
  input  logic [IW-1:0]          rd_rank,
  input  logic [PAGE_BITS-1:0]   page,
  output lrupr_pkg::unit_stat_t  stat,
  output logic [IW-1:0]          tgt_idx,
  output logic [PAGE_BITS-1:0]   ev_page,
  output logic                   wr_en,
  output logic [PAGE_BITS-1:0]   wr_page,
  output logic [IW-1:0]          wr_rank
);
  import lrupr_pkg::*;

  logic                 hit_found;
  logic [IW-1:0]        hit_idx;
  logic [IW-1:0]        hit_rank;
  logic                 empty_found;
  logic [IW-1:0]        empty_idx;
  logic                 best_found;
  logic [IW-1:0]        best_idx;
  logic [IW-1:0]        best_rank;
  logic [PAGE_BITS-1:0] best_page;
  logic [CW-1:0]        limit;

  // Accumulators of the scan pass; the first match wins in each search.
  always_ff @(posedge clk) begin
    if (rst || op.clear) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      best_found  <= 1'b0;
    end else if (op.scan) begin
      if (frame_valid && (rd_page == page) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
        hit_rank  <= rd_rank;
      end
      if (!frame_valid && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= idx;
      end
      if (frame_valid && (!best_found || (rd_rank > best_rank))) begin
        best_found <= 1'b1;
        best_idx   <= idx;
        best_rank  <= rd_rank;
        best_page  <= rd_page;
      end
    end
  end

  // Target frame and the age limit below which other frames get older.
  // A filled or replaced frame counts as older than every other frame.
  always_comb begin
    stat.hit   = hit_found;
    stat.evict = !hit_found && !empty_found;
    ev_page    = best_page;
    if (hit_found) begin
      tgt_idx = hit_idx;
      limit   = CW'(hit_rank);
    end else if (empty_found) begin
      tgt_idx = empty_idx;
      limit   = CW'(FRAMES);
    end else begin
      tgt_idx = best_idx;
      limit   = CW'(FRAMES);
    end
  end

  // Rank update of one frame during the touch pass.
  always_comb begin
    wr_en   = 1'b0;
    wr_page = rd_page;
    wr_rank = rd_rank;
    if (op.touch) begin
      if (idx == tgt_idx) begin
        wr_en   = 1'b1;
        wr_page = page;
        wr_rank = '0;
      end else if (frame_valid && (CW'(rd_rank) < limit)) begin
        wr_en = 1'b1;
        if (rd_rank < IW'(FRAMES - 1)) begin
          wr_rank = rd_rank + IW'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block: sequencer, valid bits,
// totals and result register. Depends on lrupr_pkg, lrupr_ifs, lrupr_ram, lrupr_unit.
//
//   Channel   Direction  Handshake       Contents
//   refs      in         valid / ready   page
//   results   out        valid / ready   hit, frame, evicted_valid, evicted_page,
//                                        hits_so_far, faults_so_far
//   cfg       in         cfg_we          cfg_wdata = frames_in_use
//
// For each reference, the one frame unit visits each active frame once in a scan
// pass and once in a rank update pass, one frame per cycle through the registered
// read port of the frame RAM; the result is then loaded into the output register.
// The block takes no new reference until the current result has been loaded there.
// Reset is synchronous and active high; it empties all frames, clears both
// totals and sets frames_in_use to 8 (active frame count 8, or FRAMES if smaller).
// The block takes a new reference while a finished result still waits in the
// output register; a stalled result only delays the end of the next reference.
module lru_page_replacement_top #(
  parameter int FRAMES    = lrupr_pkg::DEF_FRAMES,
  parameter int PAGE_BITS = lrupr_pkg::DEF_PAGE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
  lrupr_in_if.sink                    refs,
  lrupr_out_if.source                 results
);
  import lrupr_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int WORD_W = IW + PAGE_BITS;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]     frames_in_use;
  logic [CW-1:0]        active;
  logic [PAGE_BITS-1:0] page_reg;
  logic [FRAMES-1:0]    valid;
  logic [CW-1:0]        rd_idx;
  logic                 pend;
  logic [IW-1:0]        pend_idx;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     fault_total;
  logic                 out_valid;

  logic                 accept;
  logic                 ram_re;
  logic                 pass_done;
  logic                 load;
  unit_op_t             op;
  unit_stat_t           stat;
  logic [WORD_W-1:0]    rd_word;
  logic [IW-1:0]        tgt_idx;
  logic [PAGE_BITS-1:0] ev_page;
  logic                 wr_en;
  logic [PAGE_BITS-1:0] wr_page;
  logic [IW-1:0]        wr_rank;

  // Active frame count: zero counts as one, anything above FRAMES as FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      active = CW'(1);
    end else if (32'(frames_in_use) > FRAMES) begin
      active = CW'(FRAMES);
    end else begin
      active = CW'(frames_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A pass is over when every active frame was read and its data handled.
  assign pass_done = (rd_idx == active) && !pend;
  assign accept    = refs.valid && refs.ready;
  assign load      = (state == S_FINISH) && (!out_valid || results.ready);

  always_comb begin
    state_next = state;
    refs.ready = 1'b0;
    ram_re     = 1'b0;
    op         = '0;
    unique case (state)
      S_IDLE: begin
        refs.ready = 1'b1;
        op.clear   = refs.valid;
        if (refs.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re  = (rd_idx < active);
        op.scan = pend;
        if (pass_done) begin
          state_next = S_TOUCH;
        end
      end
      S_TOUCH: begin
        ram_re   = (rd_idx < active);
        op.touch = pend;
        if (pass_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Read address sweep; pend marks the cycle in which the RAM data arrive.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      pend   <= 1'b0;
    end else begin
      pend <= ram_re;
      if (ram_re) begin
        rd_idx <= rd_idx + CW'(1);
      end else if (pass_done) begin
        rd_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= rd_idx[IW-1:0];
    if (accept) begin
      page_reg <= PAGE_BITS'(refs.page);
    end
  end

  // Valid bits and totals change once per reference, at the end of the touch pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      hit_total   <= '0;
      fault_total <= '0;
    end else if ((state == S_TOUCH) && pass_done) begin
      valid[tgt_idx] <= 1'b1;
      if (stat.hit) begin
        if (hit_total != '1) begin
          hit_total <= hit_total + CNT_W'(1);
        end
      end else if (fault_total != '1) begin
        fault_total <= fault_total + CNT_W'(1);
      end
    end
  end

  lrupr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pend_idx),
    .wdata ({wr_rank, wr_page}),
    .re    (ram_re),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rd_word)
  );

  lrupr_unit #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_unit (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .idx         (pend_idx),
    .frame_valid (valid[pend_idx]),
    .rd_page     (rd_word[PAGE_BITS-1:0]),
    .rd_rank     (rd_word[WORD_W-1:PAGE_BITS]),
    .page        (page_reg),
    .stat        (stat),
    .tgt_idx     (tgt_idx),
    .ev_page     (ev_page),
    .wr_en       (wr_en),
    .wr_page     (wr_page),
    .wr_rank     (wr_rank)
  );

  // Result register; it holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.hit           <= stat.hit;
      results.frame         <= FRAME_W'(tgt_idx);
      results.evicted_valid <= stat.evict;
      results.evicted_page  <= stat.evict ? PAGE_W'(ev_page) : '0;
      results.hits_so_far   <= hit_total;
      results.faults_so_far <= fault_total;
    end
  end

  assign results.valid = out_valid;

  // The frame RAM is written only during the rank update pass.
  a_write_in_touch: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_TOUCH))
    else $error("frame RAM written outside the touch pass");

  // Ready drops after a reference transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !refs.ready)
    else $error("ready high right after a reference transfer");

  // A hit never reports an evicted page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.hit && results.evicted_valid))
    else $error("hit result with an evicted page");

  // The totals never decrease.
  a_totals_grow: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((hit_total >= $past(hit_total)) &&
                     (fault_total >= $past(fault_total))))
    else $error("hit or fault total decreased");

endmodule
